>>> src/mlac_pkg.sv
// ----------------------------------------------------------------------------
// mlac_pkg: shared definitions for the occupancy lamp controller
// Event codes, mode and level codes, register indexes, controller/datapath
// interface structs and small arithmetic helpers.
// ----------------------------------------------------------------------------
package mlac_pkg;

  // Event codes carried in the command field.
  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_LUX    = 2'd1;
  localparam logic [1:0] CMD_MOTION = 2'd2;
  localparam logic [1:0] CMD_MODE   = 2'd3;

  // Lamp modes.
  localparam logic [1:0] LAMP_OFF   = 2'd0;
  localparam logic [1:0] LAMP_ON    = 2'd1;
  localparam logic [1:0] LAMP_AUTO  = 2'd2;
  localparam logic [1:0] LAMP_SLEEP = 2'd3;

  // Automatic light levels.
  localparam logic [1:0] LVL_OFF  = 2'd0;
  localparam logic [1:0] LVL_DIM  = 2'd1;
  localparam logic [1:0] LVL_FULL = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_THRESHOLD  = 2'd0;
  localparam logic [1:0] REG_HOLD_TIME  = 2'd1;
  localparam logic [1:0] REG_BRIGHTNESS = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [7:0] THRESHOLD_RST  = 8'd10;
  localparam logic [7:0] HOLD_TIME_RST  = 8'd12;
  localparam logic [7:0] BRIGHTNESS_RST = 8'd20;

  // Timer and cut-off constants.
  localparam logic [2:0]  RECHECK_TICKS = 3'd5;
  localparam logic [15:0] LUX_MAX       = 16'hffff;

  // Square root unit: 30*hold fits in 13 bits, its root in 7 bits.
  localparam int ROOT_W  = 7;
  localparam int LIM_W   = 13;
  localparam int ROOT_IW = $clog2(ROOT_W);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the accepted input transaction
    logic exec;      // apply the event to the lamp state
    logic root_step; // one bit of the square root
    logic dim_load;  // load the dimmed hold length
    logic out_load;  // load the result register
  } mlac_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_dim;  // this event steps the light from full to dimmed
    logic root_last; // the current root step is the final one
    logic out_free;  // result register can take a new result
  } mlac_stat_t;

  // Floor of b/3 for 8-bit b, by reciprocal multiplication (exact below 512).
  function automatic logic [7:0] div3(input logic [7:0] b);
    logic [16:0] prod;
    prod = {9'd0, b} * 17'd171;
    return prod[16:9];
  endfunction

endpackage

>>> src/motion_light_auto_controller.sv
// ----------------------------------------------------------------------------
// motion_light_auto_controller: occupancy lamp controller
// Takes tick, lux, motion and mode events and returns the lamp state and
// drive brightness after each one. Configuration through an APB port.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// s_*       in         event transaction (tuser: command; tdata: lux, pir, mode)
// m_*       out        result transaction (level, mode, drive, cut-off)
// APB       in/out     lux_threshold, hold_time, brightness at 0x0, 0x4, 0x8
//
// After acceptance an event passes through the execute and output states,
// and its result is registered in the output state; a tick that dims the
// light also passes through the root and dim-load states in between, as
// the 7-bit square root runs one bit per cycle. The result register holds
// while m_tready is low, and the next event is accepted meanwhile; the
// block waits to load its next result until the register is free. Reset is
// synchronous and clears the configuration, sequencer, lamp state and m_tvalid.
// ----------------------------------------------------------------------------
module motion_light_auto_controller import mlac_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // Event input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [15:0] lux_value, [16] pir_level, [18:17] new_mode
  input  logic [1:0]  s_tuser,   // [1:0] command
  // Result output stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [1:0] light_level, [3:2] lamp_mode_out,
                                 // [11:4] drive_brightness, [27:12] lux_cutoff
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]  lux_threshold;
  logic [7:0]  hold_time;
  logic [7:0]  brightness;
  logic        cfg_write;
  logic [1:0]  reg_index;

  mlac_cmd_t   cmd;
  mlac_stat_t  stat;

  logic [1:0]  light_level;
  logic [1:0]  lamp_mode_out;
  logic [7:0]  drive_brightness;
  logic [15:0] lux_cutoff;

  // Configuration registers.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      lux_threshold <= THRESHOLD_RST;
      hold_time     <= HOLD_TIME_RST;
      brightness    <= BRIGHTNESS_RST;
    end else if (cfg_write) begin
      case (reg_index)
        REG_THRESHOLD:  lux_threshold <= pwdata[7:0];
        REG_HOLD_TIME:  hold_time     <= pwdata[7:0];
        REG_BRIGHTNESS: brightness    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_THRESHOLD:  prdata = {24'd0, lux_threshold};
      REG_HOLD_TIME:  prdata = {24'd0, hold_time};
      REG_BRIGHTNESS: prdata = {24'd0, brightness};
      default:        prdata = 32'd0;
    endcase
  end

  // Sequencer.
  mlac_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Lamp state and result register.
  mlac_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .in_command       (s_tuser),
    .in_lux_value     (s_tdata[15:0]),
    .in_pir_level     (s_tdata[16]),
    .in_new_mode      (s_tdata[18:17]),
    .lux_threshold    (lux_threshold),
    .hold_time        (hold_time),
    .brightness       (brightness),
    .out_valid        (m_tvalid),
    .out_ready        (m_tready),
    .light_level      (light_level),
    .lamp_mode_out    (lamp_mode_out),
    .drive_brightness (drive_brightness),
    .lux_cutoff       (lux_cutoff)
  );

  assign m_tdata = {4'd0, lux_cutoff, drive_brightness, lamp_mode_out, light_level};

`ifndef SYNTHESIS
  // An accepted transaction keeps the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("event accepted on consecutive cycles");

  // The automatic level never takes the unused code.
  a_level_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[1:0] != 2'd3)
    else $error("illegal light level in result");

  // With the light off and the mode not on, nothing is driven.
  a_dark_when_off: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == LVL_OFF && m_tdata[3:2] != LAMP_ON
      |-> m_tdata[11:4] == 8'd0)
    else $error("brightness driven while light is off");
`endif

endmodule

>>> src/mlac_ctrl.sv
// ----------------------------------------------------------------------------
// mlac_ctrl: sequencing state machine
// Accepts one transaction, applies it, runs the square root when the light
// dims, and hands the result to the output register.
// ----------------------------------------------------------------------------
module mlac_ctrl import mlac_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  mlac_stat_t stat,
  output mlac_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_ROOT,
    S_DIM,
    S_OUT
  } state_t;

  state_t state;
  state_t state_next;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (s_tvalid) state_next = S_EXEC;
      S_EXEC: state_next = stat.need_dim ? S_ROOT : S_OUT;
      S_ROOT: if (stat.root_last) state_next = S_DIM;
      S_DIM:  state_next = S_OUT;
      S_OUT:  if (stat.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Commands decoded from the state.
  assign s_tready      = (state == S_IDLE);
  assign cmd.capture   = (state == S_IDLE) && s_tvalid;
  assign cmd.exec      = (state == S_EXEC);
  assign cmd.root_step = (state == S_ROOT);
  assign cmd.dim_load  = (state == S_DIM);
  assign cmd.out_load  = (state == S_OUT) && stat.out_free;

endmodule

>>> src/mlac_dp.sv
// ----------------------------------------------------------------------------
// mlac_dp: lamp state datapath
// Holds the lamp state, timers and cut-off, the bit-serial square root for
// the dimmed hold, and the result register.
// ----------------------------------------------------------------------------
module mlac_dp import mlac_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  mlac_cmd_t   cmd,
  output mlac_stat_t  stat,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_lux_value,
  input  logic        in_pir_level,
  input  logic [1:0]  in_new_mode,
  input  logic [7:0]  lux_threshold,
  input  logic [7:0]  hold_time,
  input  logic [7:0]  brightness,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  light_level,
  output logic [1:0]  lamp_mode_out,
  output logic [7:0]  drive_brightness,
  output logic [15:0] lux_cutoff
);

  // Captured input transaction.
  logic [1:0]  item_cmd;
  logic [15:0] item_lux;
  logic        item_pir;
  logic [1:0]  item_mode;

  // Lamp state.
  logic [1:0]  auto_level, auto_level_next;
  logic [1:0]  lamp_mode, lamp_mode_next;
  logic [15:0] lux_off_level, lux_off_level_next;
  logic [15:0] last_lux, last_lux_next;
  logic [10:0] hold_count, hold_count_next;
  logic        hold_running, hold_running_next;
  logic [2:0]  recheck_count, recheck_count_next;
  logic        recheck_running, recheck_running_next;

  // Square root unit.
  logic [ROOT_W-1:0]  root;
  logic [ROOT_IW-1:0] root_bit;
  logic [ROOT_W-1:0]  trial;
  logic [2*ROOT_W-1:0] trial_sq;
  logic [LIM_W-1:0]   root_lim;

  // Arithmetic helpers.
  logic [9:0]  thr3;
  logic [8:0]  cut_a;
  logic [17:0] lux3;
  logic [16:0] cut_b;
  logic [16:0] cut_max;
  logic [15:0] cut_calc;
  logic [10:0] hold_full;
  logic [7:0]  drive;

  // Capture the accepted transaction.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_cmd  <= in_command;
      item_lux  <= in_lux_value;
      item_pir  <= in_pir_level;
      item_mode <= in_new_mode;
    end
  end

  // Cut-off after recheck: max(ceil(1.5*threshold), floor(1.5*lux)), saturated.
  assign thr3     = {2'd0, lux_threshold} + {1'b0, lux_threshold, 1'b0};
  assign cut_a    = 9'((thr3 + 10'd1) >> 1);
  assign lux3     = {2'd0, last_lux} + {1'b0, last_lux, 1'b0};
  assign cut_b    = lux3[17:1];
  assign cut_max  = (cut_b > {8'd0, cut_a}) ? cut_b : {8'd0, cut_a};
  assign cut_calc = cut_max[16] ? LUX_MAX : cut_max[15:0];

  // Full hold is five times the hold unit.
  assign hold_full = {3'd0, hold_time} + {1'b0, hold_time, 2'd0};

  // Event handling.
  always_comb begin
    auto_level_next      = auto_level;
    lamp_mode_next       = lamp_mode;
    lux_off_level_next   = lux_off_level;
    last_lux_next        = last_lux;
    hold_count_next      = hold_count;
    hold_running_next    = hold_running;
    recheck_count_next   = recheck_count;
    recheck_running_next = recheck_running;
    case (item_cmd)
      CMD_TICK: begin
        if (recheck_running) begin
          if (recheck_count <= 3'd1) begin
            recheck_running_next = 1'b0;
            recheck_count_next   = 3'd0;
            lux_off_level_next   = cut_calc;
          end else begin
            recheck_count_next = recheck_count - 3'd1;
          end
        end
        if (hold_running) begin
          if (hold_count <= 11'd1) begin
            hold_running_next = 1'b0;
            hold_count_next   = 11'd0;
            if (auto_level != LVL_OFF) begin
              auto_level_next = auto_level - 2'd1;
            end
            // Stepping down from full starts the dimmed hold; its length
            // is loaded once the square root is done.
            if (auto_level == LVL_FULL) begin
              hold_running_next = 1'b1;
            end
          end else begin
            hold_count_next = hold_count - 11'd1;
          end
        end
      end
      CMD_LUX: begin
        last_lux_next = item_lux;
        if (auto_level != LVL_OFF && item_lux > lux_off_level) begin
          auto_level_next = LVL_OFF;
        end
        if (lamp_mode == LAMP_SLEEP && item_lux > {8'd0, lux_threshold}) begin
          lamp_mode_next = LAMP_AUTO;
        end
      end
      CMD_MOTION: begin
        if (lamp_mode == LAMP_AUTO) begin
          if (item_pir) begin
            if (last_lux < {8'd0, lux_threshold}) begin
              hold_running_next    = 1'b0;
              hold_count_next      = 11'd0;
              lux_off_level_next   = LUX_MAX;
              auto_level_next      = LVL_FULL;
              recheck_count_next   = RECHECK_TICKS;
              recheck_running_next = 1'b1;
            end
          end else begin
            hold_count_next   = hold_full;
            hold_running_next = 1'b1;
          end
        end
      end
      CMD_MODE: lamp_mode_next = item_mode;
      default: lamp_mode_next = lamp_mode;
    endcase
  end

  assign stat.need_dim = (item_cmd == CMD_TICK) && hold_running &&
                         (hold_count <= 11'd1) && (auto_level == LVL_FULL);

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      auto_level      <= LVL_OFF;
      lamp_mode       <= LAMP_OFF;
      lux_off_level   <= LUX_MAX;
      last_lux        <= 16'd0;
      hold_count      <= 11'd0;
      hold_running    <= 1'b0;
      recheck_count   <= 3'd0;
      recheck_running <= 1'b0;
    end else if (cmd.exec) begin
      auto_level      <= auto_level_next;
      lamp_mode       <= lamp_mode_next;
      lux_off_level   <= lux_off_level_next;
      last_lux        <= last_lux_next;
      hold_count      <= hold_count_next;
      hold_running    <= hold_running_next;
      recheck_count   <= recheck_count_next;
      recheck_running <= recheck_running_next;
    end else if (cmd.dim_load) begin
      // round(sqrt(7.5*h)) equals (isqrt(30*h) + 1) / 2.
      hold_count <= 11'((({1'b0, root}) + 8'd1) >> 1);
    end
  end

  // Restoring square root of 30*hold_time, one result bit per cycle.
  assign root_lim  = {hold_time, 5'd0} - {4'd0, hold_time, 1'b0};
  assign trial     = root | (ROOT_W'(1) << root_bit);
  assign trial_sq  = trial * trial;
  assign stat.root_last = (root_bit == '0);

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      root     <= '0;
      root_bit <= ROOT_IW'(ROOT_W - 1);
    end else if (cmd.root_step) begin
      if (trial_sq <= {1'b0, root_lim}) begin
        root <= trial;
      end
      root_bit <= root_bit - ROOT_IW'(1);
    end
  end

  // Drive brightness from the settled state.
  always_comb begin
    if (auto_level == LVL_DIM) begin
      drive = div3(brightness);
    end else if (auto_level != LVL_OFF || lamp_mode == LAMP_ON) begin
      drive = brightness;
    end else begin
      drive = 8'd0;
    end
  end

  // Result register.
  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      light_level      <= auto_level;
      lamp_mode_out    <= lamp_mode;
      drive_brightness <= drive;
      lux_cutoff       <= lux_off_level;
    end
  end

endmodule

>>> dv/tb_motion_light_auto_controller.sv
// ----------------------------------------------------------------------------
// tb_motion_light_auto_controller: self-checking bench for the lamp controller
// Streams tick, lux, motion and mode events into the block and predicts each
// result in a cycle-free model of the lamp state. Every result transaction is
// compared field by field against the oldest prediction. The run steps
// through several register settings written over APB while the block is
// idle. It starts with directed sequences and follows them with random
// occupancy scenarios mixed with noise, with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_motion_light_auto_controller import mlac_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // Register index that the block has no register for.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // Cycles to let pass after the last result before touching the registers.
  localparam int SETTLE_CYCLES = 16;

  // One input event and the lamp status that it leads to.
  typedef struct {
    logic [1:0]  cmd;
    logic [15:0] lux;
    logic        pir;
    logic [1:0]  mode;
    int unsigned gap;
  } lamp_event_t;

  typedef struct {
    logic [1:0]  level;
    logic [1:0]  mode;
    logic [7:0]  drive;
    logic [15:0] cutoff;
  } lamp_status_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // [15:0] lux_value, [16] pir_level, [18:17] new_mode
  logic [1:0]  s_tuser = '0;   // [1:0] command
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [1:0] light_level, [3:2] lamp_mode_out,
                               // [11:4] drive_brightness, [27:12] lux_cutoff
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  motion_light_auto_controller i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Register copies as the lamp model sees them.
  logic [7:0] cfg_thr    = THRESHOLD_RST;
  logic [7:0] cfg_hold   = HOLD_TIME_RST;
  logic [7:0] cfg_bright = BRIGHTNESS_RST;

  // Lamp state held by the model.
  logic [1:0]  lvl         = LVL_OFF;
  logic [1:0]  lmode       = LAMP_OFF;
  logic [15:0] cutoff_q    = LUX_MAX;
  logic [15:0] lux_seen    = '0;
  logic [10:0] hold_cnt    = '0;
  logic        hold_on     = 1'b0;
  logic [2:0]  recheck_cnt = '0;
  logic        recheck_on  = 1'b0;

  lamp_event_t  event_q[$];
  lamp_status_t status_q[$];
  lamp_event_t  cur_ev;
  int unsigned  n_queued = 0;
  int unsigned  n_taken = 0;
  int unsigned  src_wait = 0;
  int unsigned  sink_wait = 0;
  int unsigned  results_seen = 0;
  int unsigned  err_count = 0;
  bit           jitter_on = 1'b1;

  initial begin
    forever #5 clk = ~clk;
  end

  // Applies one event to the lamp model and returns the status after it.
  function automatic lamp_status_t apply_event(input lamp_event_t ev);
    lamp_status_t st;
    int unsigned  lo_lim;
    int unsigned  lux_lim;
    case (ev.cmd)
      CMD_TICK: begin
        // The recheck and the hold count down independently on one tick.
        if (recheck_on) begin
          if (recheck_cnt <= 1) begin
            recheck_on = 1'b0;
            recheck_cnt = '0;
            lo_lim = (3 * cfg_thr + 1) / 2;
            lux_lim = (3 * lux_seen) / 2;
            if (lux_lim > lo_lim) lo_lim = lux_lim;
            cutoff_q = (lo_lim > LUX_MAX) ? LUX_MAX : 16'(lo_lim);
          end else begin
            recheck_cnt = recheck_cnt - 1'b1;
          end
        end
        if (hold_on) begin
          if (hold_cnt <= 1) begin
            hold_on = 1'b0;
            hold_cnt = '0;
            if (lvl != LVL_OFF) lvl = lvl - 1'b1;
            // Reaching the dimmed level starts a hold of round(sqrt(7.5*hold)).
            if (lvl == LVL_DIM) begin
              hold_cnt = 11'($rtoi($sqrt(7.5 * cfg_hold) + 0.5));
              hold_on = 1'b1;
            end
          end else begin
            hold_cnt = hold_cnt - 1'b1;
          end
        end
      end
      CMD_LUX: begin
        lux_seen = ev.lux;
        if (lvl != LVL_OFF && ev.lux > cutoff_q) lvl = LVL_OFF;
        if (lmode == LAMP_SLEEP && ev.lux > cfg_thr) lmode = LAMP_AUTO;
      end
      CMD_MOTION: begin
        if (lmode == LAMP_AUTO) begin
          if (ev.pir) begin
            if (lux_seen < cfg_thr) begin
              hold_on = 1'b0;
              hold_cnt = '0;
              cutoff_q = LUX_MAX;
              lvl = LVL_FULL;
              recheck_cnt = RECHECK_TICKS;
              recheck_on = 1'b1;
            end
          end else begin
            hold_cnt = 11'(5 * cfg_hold);
            hold_on = 1'b1;
          end
        end
      end
      default: begin
        lmode = ev.mode;
      end
    endcase
    st.level = lvl;
    st.mode = lmode;
    st.cutoff = cutoff_q;
    if (lvl == LVL_DIM) st.drive = 8'(cfg_bright / 3);
    else if (lvl != LVL_OFF || lmode == LAMP_ON) st.drive = cfg_bright;
    else st.drive = '0;
    return st;
  endfunction

  task automatic report_mismatch(input string msg);
    err_count++;
    $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  // Event source: presents queued events, each after its own idle gap.
  always @(posedge clk) begin : source
    lamp_status_t st;
    if (rst) begin
      s_tvalid <= 1'b0;
      src_wait <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        st = apply_event(cur_ev);
        status_q.push_back(st);
        n_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (event_q.size() == 0) begin
          s_tvalid <= 1'b0;
        end else if (src_wait < event_q[0].gap) begin
          src_wait <= src_wait + 1;
          s_tvalid <= 1'b0;
        end else begin
          cur_ev = event_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {5'd0, cur_ev.mode, cur_ev.pir, cur_ev.lux};
          s_tuser <= cur_ev.cmd;
          src_wait <= 0;
        end
      end
    end
  end

  // Result sink: checks each result transaction and stalls at random, with
  // two long hold-offs so that the block backs up into its input.
  always @(posedge clk) begin : sink
    lamp_status_t want;
    lamp_status_t got;
    int unsigned  pause;
    if (rst) begin
      m_tready <= 1'b0;
      sink_wait <= 0;
    end else begin
      pause = sink_wait;
      if (m_tvalid && m_tready) begin
        results_seen++;
        got.level = m_tdata[1:0];
        got.mode = m_tdata[3:2];
        got.drive = m_tdata[11:4];
        got.cutoff = m_tdata[27:12];
        if (status_q.size() == 0) begin
          report_mismatch("result transaction with no event outstanding");
        end else begin
          want = status_q.pop_front();
          if (got.level !== want.level)
            report_mismatch($sformatf("light_level %0d, expected %0d", got.level, want.level));
          if (got.mode !== want.mode)
            report_mismatch($sformatf("lamp_mode_out %0d, expected %0d", got.mode, want.mode));
          if (got.drive !== want.drive)
            report_mismatch($sformatf("drive_brightness %0d, expected %0d",
                                      got.drive, want.drive));
          if (got.cutoff !== want.cutoff)
            report_mismatch($sformatf("lux_cutoff %0d, expected %0d", got.cutoff, want.cutoff));
        end
        pause = jitter_on ? $urandom_range(0, 8) : 0;
        if (results_seen == 100 || results_seen == 600) pause = 400;
      end
      if (pause > 0) begin
        m_tready <= 1'b0;
        sink_wait <= pause - 1;
      end else begin
        m_tready <= 1'b1;
        sink_wait <= 0;
      end
    end
  end

  task automatic queue_event(input logic [1:0] cmd, input logic [15:0] lux,
                             input logic pir, input logic [1:0] mode);
    lamp_event_t ev;
    ev.cmd = cmd;
    ev.lux = lux;
    ev.pir = pir;
    ev.mode = mode;
    ev.gap = jitter_on ? $urandom_range(0, 8) : 0;
    event_q.push_back(ev);
    n_queued++;
  endtask

  // Fields that an event does not use carry random values.
  task automatic push_tick();
    queue_event(CMD_TICK, 16'($urandom), 1'($urandom), 2'($urandom));
  endtask

  task automatic push_lux(input logic [15:0] lux);
    queue_event(CMD_LUX, lux, 1'($urandom), 2'($urandom));
  endtask

  task automatic push_motion(input logic pir);
    queue_event(CMD_MOTION, 16'($urandom), pir, 2'($urandom));
  endtask

  task automatic push_mode(input logic [1:0] mode);
    queue_event(CMD_MODE, 16'($urandom), 1'($urandom), mode);
  endtask

  // Lux value: dark means at or below the threshold, else spread widely.
  function automatic logic [15:0] pick_lux(input bit dark);
    if (dark) return 16'($urandom_range(0, cfg_thr));
    case ($urandom_range(0, 4))
      0: return LUX_MAX;
      1: return 16'(cfg_thr + $urandom_range(0, 2));
      2: return 16'($urandom_range(0, 600));
      default: return 16'($urandom);
    endcase
  endfunction

  // One occupancy episode: an optional wake or entry into auto, motion mostly
  // in the dark, a few ticks and lux samples, motion mostly ending, and ticks through the holds.
  task automatic queue_scenario();
    int unsigned pick;
    int unsigned span;
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      push_mode(LAMP_SLEEP);
      push_lux(pick_lux(1'b0));
    end else if (pick < 6) begin
      push_mode(LAMP_AUTO);
    end
    push_lux(pick_lux($urandom_range(0, 4) != 0));
    push_motion(1'b1);
    repeat ($urandom_range(0, 7)) push_tick();
    if ($urandom_range(0, 1)) push_lux(pick_lux(1'b0));
    push_motion($urandom_range(0, 4) == 0);
    span = 7 * cfg_hold + 4;
    if (span > 45) span = 45;
    repeat ($urandom_range(0, span)) push_tick();
  endtask

  // APB write: setup cycle, then access cycle; the register takes the value
  // at the end of the access cycle.
  task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_THRESHOLD:  cfg_thr = val;
      REG_HOLD_TIME:  cfg_hold = val;
      REG_BRIGHTNESS: cfg_bright = val;
      default: ;
    endcase
  endtask

  task automatic cfg_check(input logic [1:0] idx);
    logic [7:0] want;
    case (idx)
      REG_THRESHOLD:  want = cfg_thr;
      REG_HOLD_TIME:  want = cfg_hold;
      default:        want = cfg_bright;
    endcase
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[7:0] !== want)
      report_mismatch($sformatf("register %0d reads %0d, expected %0d", idx, prdata[7:0], want));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(input logic [7:0] thr, input logic [7:0] hold,
                            input logic [7:0] bright);
    cfg_write(REG_THRESHOLD, thr);
    cfg_write(REG_HOLD_TIME, hold);
    cfg_write(REG_BRIGHTNESS, bright);
    cfg_check(REG_THRESHOLD);
    cfg_check(REG_HOLD_TIME);
    cfg_check(REG_BRIGHTNESS);
  endtask

  // Waits until every queued event has been taken and answered, then lets
  // the block settle so that the registers may be written.
  task automatic wait_idle();
    while (n_taken != n_queued || status_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned ph;
    int unsigned start;
    logic [7:0]  thr;
    logic [7:0]  hold;
    logic [7:0]  bright;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: mode on, motion outside auto, sleep wake, motion in light,
    // motion in the dark, saturated cut-off, full hold, dimmed hold.
    set_config(8'd200, 8'd1, 8'd255);
    push_tick();
    push_mode(LAMP_ON);
    push_motion(1'b1);
    push_mode(LAMP_SLEEP);
    push_lux(16'd100);
    push_lux(16'd201);
    push_motion(1'b1);
    push_lux(16'd0);
    push_motion(1'b1);
    push_lux(LUX_MAX);
    repeat (5) push_tick();
    push_motion(1'b0);
    repeat (5) push_tick();
    repeat (3) push_tick();
    // A hold that runs out while the light is already off.
    push_motion(1'b0);
    repeat (5) push_tick();
    wait_idle();

    // Directed: zero hold length, lux above the cut-off, unused register.
    set_config(8'd255, 8'd0, 8'd100);
    cfg_write(REG_UNUSED, 8'hff);
    cfg_check(REG_HOLD_TIME);
    push_mode(LAMP_AUTO);
    push_lux(16'd0);
    push_motion(1'b1);
    repeat (5) push_tick();
    push_lux(16'd384);
    push_motion(1'b1);
    push_lux(16'd3);
    push_motion(1'b1);
    push_motion(1'b0);
    repeat (3) push_tick();
    wait_idle();

    // Random phases over a spread of settings, extremes included.
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin thr = 8'd10;  hold = 8'd2;   bright = 8'd20;  end
        1: begin thr = 8'd0;   hold = 8'd3;   bright = 8'd255; end
        2: begin thr = 8'd255; hold = 8'd1;   bright = 8'd1;   end
        3: begin thr = 8'($urandom); hold = 8'd255; bright = 8'($urandom); end
        4: begin thr = 8'd128; hold = 8'd4;   bright = 8'd3;   end
        5: begin thr = 8'($urandom); hold = 8'($urandom_range(1, 6)); bright = 8'd0; end
        6: begin thr = 8'($urandom); hold = 8'd5; bright = 8'($urandom); end
        default: begin thr = 8'd1; hold = 8'd1; bright = 8'd254; end
      endcase
      // One phase runs with no random idling on either stream.
      jitter_on = (ph != 4);
      set_config(thr, hold, bright);
      start = n_queued;
      while (n_queued - start < 105) begin
        if ($urandom_range(0, 4) != 0) queue_scenario();
        else queue_event(2'($urandom), 16'($urandom), 1'($urandom), 2'($urandom));
      end
      wait_idle();
    end

    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin : watchdog
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

>>> sim.f
src/mlac_pkg.sv
src/mlac_ctrl.sv
src/mlac_dp.sv
src/motion_light_auto_controller.sv
dv/tb_motion_light_auto_controller.sv
